FILE: hw/rtl/lsac_pkg.sv
// Shared types and constants for the LRU set-associative cache tag model.
// Used by the channel interfaces, the compare unit and the top level.
package lsac_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_AW   = SET_W + WAY_W;
  localparam int NUM_LINES = 1 << LINE_AW;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 64;
  localparam int TOTAL_W = 32;
  localparam int MODE_W  = 2;
  localparam int HITS_W  = 2;
  localparam int SHIFT_W = 6;

  localparam int SB_W   = 3;
  localparam int WAYS_W = 4;
  localparam int BB_W   = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [SB_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;
  localparam logic [BB_W-1:0]   BLOCK_BITS_RST = 5'd4;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic match;
    logic older;
  } cmp_res_t;

endpackage

FILE: hw/rtl/lsac_req_if.sv
// Access request channel: mode and byte address with valid/ready.
// Depends on lsac_pkg for field widths.
interface lsac_req_if;
  logic                        valid;
  logic                        ready;
  logic [lsac_pkg::MODE_W-1:0] mode;
  logic [lsac_pkg::ADDR_W-1:0] address;

  modport source (output valid, output mode, output address, input ready);
  modport sink (input valid, input mode, input address, output ready);
endinterface

FILE: hw/rtl/lsac_rsp_if.sv
// Result channel: per-access hit, miss and eviction flags plus running totals.
// Depends on lsac_pkg for field widths.
interface lsac_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lsac_pkg::HITS_W-1:0]  hit_count;
  logic                         missed;
  logic                         evicted;
  logic [lsac_pkg::TOTAL_W-1:0] total_hits;
  logic [lsac_pkg::TOTAL_W-1:0] total_misses;
  logic [lsac_pkg::TOTAL_W-1:0] total_evictions;

  modport source (output valid, output hit_count, output missed, output evicted,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink (input valid, input hit_count, input missed, input evicted,
                input total_hits, input total_misses, input total_evictions,
                output ready);
endinterface

FILE: hw/rtl/lsac_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
// Depends on lsac_pkg for field widths.
interface lsac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsac_pkg::CFG_IDX_W-1:0]  index;
  logic [lsac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lsac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module lsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lsac_cmp.sv
// Shared compare unit: tag match and LRU age compare for one cache line per cycle.
// Depends on lsac_pkg for the line and result types.
module lsac_cmp (
  input  lsac_pkg::line_t                 line_i,
  input  logic [lsac_pkg::TAG_W-1:0]      tag_i,
  input  logic [lsac_pkg::STAMP_W-1:0]    oldest_i,
  output lsac_pkg::cmp_res_t              res_o
);

  always_comb begin
    res_o.match = line_i.valid && (line_i.tag == tag_i);
    res_o.older = line_i.stamp < oldest_i;
  end

endmodule

FILE: hw/rtl/lru_set_assoc_cache_sim_unit.sv
// Top level of the LRU set-associative cache tag model: sequencer, trackers and totals.
// Depends on lsac_pkg, the three channel interfaces, lsac_ram and lsac_cmp.
//
// Channel  Dir   Payload                                              Handshake
// req      in    mode, address                                        valid/ready
// rsp      out   hit_count, missed, evicted, total_hits/misses/evicts valid/ready
// cfg      in    index, data                                          valid/ready
//
// An access runs from acceptance through PREP, SCAN (one line RAM read per way in use,
// feeding the single compare unit), DRAIN and FINISH; an unused mode skips to FINISH.
// After reset a clearing pass writes all 512 lines, one per cycle, with req.ready low.
// A result waits in an output register; the next item can be accepted in the cycle
// after it loads, and completion stalls only while that register is still full and
// rsp.ready is low. cfg.ready is always high.
module lru_set_assoc_cache_sim_unit (
  input logic         clk_i,
  input logic         rst_ni,
  lsac_req_if.sink    req,
  lsac_rsp_if.source  rsp,
  lsac_cfg_if.sink    cfg
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [lsac_pkg::SB_W-1:0]    set_bits_q;
  logic [lsac_pkg::WAYS_W-1:0]  ways_q;
  logic [lsac_pkg::BB_W-1:0]    block_bits_q;

  logic [lsac_pkg::MODE_W-1:0]  mode_q;
  logic [lsac_pkg::ADDR_W-1:0]  addr_q;
  logic [lsac_pkg::SET_W-1:0]   set_q;
  logic [lsac_pkg::TAG_W-1:0]   tag_q;
  logic [lsac_pkg::LINE_AW-1:0] clr_q;
  logic [lsac_pkg::WAY_W-1:0]   rd_way_q;
  logic [lsac_pkg::WAY_W-1:0]   cmp_way_q;
  logic                         issued_q;

  logic                         hit_q;
  logic                         full_q;
  logic [lsac_pkg::WAY_W-1:0]   hit_way_q;
  logic [lsac_pkg::WAY_W-1:0]   empty_way_q;
  logic [lsac_pkg::WAY_W-1:0]   victim_q;
  logic [lsac_pkg::STAMP_W-1:0] oldest_q;

  logic [lsac_pkg::STAMP_W-1:0] clock_q;
  logic [lsac_pkg::TOTAL_W-1:0] hit_total_q;
  logic [lsac_pkg::TOTAL_W-1:0] miss_total_q;
  logic [lsac_pkg::TOTAL_W-1:0] evict_total_q;

  logic                         rsp_valid_q;
  logic [lsac_pkg::HITS_W-1:0]  rsp_hits_q;
  logic                         rsp_miss_q;
  logic                         rsp_evict_q;

  int                           sb_eff;
  int                           ways_eff;
  logic [lsac_pkg::SET_W-1:0]   set_mask;
  logic [lsac_pkg::SHIFT_W-1:0] tag_shift;
  logic [lsac_pkg::ADDR_W-1:0]  addr_sh;
  logic [lsac_pkg::WAY_W-1:0]   last_way;

  logic                         ram_we;
  logic [lsac_pkg::LINE_AW-1:0] ram_waddr;
  lsac_pkg::line_t              ram_wdata;
  logic                         ram_re;
  lsac_pkg::line_t              ram_rdata;
  lsac_pkg::cmp_res_t           cmp_res;

  logic                         out_free;
  logic                         finish_go;
  logic                         do_access;
  logic                         is_modify;
  logic [lsac_pkg::HITS_W-1:0]  acc_hits;
  logic                         acc_miss;
  logic                         acc_evict;
  logic [lsac_pkg::WAY_W-1:0]   tgt_way;
  logic [lsac_pkg::STAMP_W-1:0] clock_next;
  logic [lsac_pkg::TOTAL_W:0]   hit_sum;

  always_comb begin
    sb_eff = (int'(set_bits_q) > lsac_pkg::MAX_SET_BITS) ? lsac_pkg::MAX_SET_BITS
                                                         : int'(set_bits_q);
    ways_eff = int'(ways_q);
    if (ways_eff == 0) begin
      ways_eff = 1;
    end else if (ways_eff > lsac_pkg::MAX_WAYS) begin
      ways_eff = lsac_pkg::MAX_WAYS;
    end
    for (int i = 0; i < lsac_pkg::SET_W; i++) begin
      set_mask[i] = (i < sb_eff);
    end
    tag_shift = lsac_pkg::SHIFT_W'(sb_eff + int'(block_bits_q));
    addr_sh   = addr_q >> block_bits_q;
    last_way  = lsac_pkg::WAY_W'(ways_eff - 1);
  end

  lsac_cmp u_cmp (
    .line_i   (ram_rdata),
    .tag_i    (tag_q),
    .oldest_i (oldest_q),
    .res_o    (cmp_res)
  );

  always_comb begin
    out_free   = !rsp_valid_q || rsp.ready;
    finish_go  = (state_q == ST_FINISH) && out_free;
    do_access  = (mode_q != lsac_pkg::MODE_NONE);
    is_modify  = (mode_q == lsac_pkg::MODE_MODIFY);
    acc_hits   = do_access ? (lsac_pkg::HITS_W'(hit_q) + lsac_pkg::HITS_W'(is_modify))
                           : '0;
    acc_miss   = do_access && !hit_q;
    acc_evict  = acc_miss && full_q;
    tgt_way    = hit_q ? hit_way_q : (full_q ? victim_q : empty_way_q);
    clock_next = clock_q + (is_modify ? lsac_pkg::STAMP_W'(2) : lsac_pkg::STAMP_W'(1));
    hit_sum    = {1'b0, hit_total_q} + (lsac_pkg::TOTAL_W + 1)'(acc_hits);

    ram_re    = (state_q == ST_SCAN);
    ram_we    = (state_q == ST_CLEAR) || (finish_go && do_access);
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : {set_q, tgt_way};
    ram_wdata = '0;
    if (state_q != ST_CLEAR) begin
      ram_wdata.valid = 1'b1;
      ram_wdata.tag   = tag_q;
      ram_wdata.stamp = clock_next;
    end
  end

  lsac_ram #(
    .WIDTH (lsac_pkg::LINE_W),
    .DEPTH (lsac_pkg::NUM_LINES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i ({set_q, rd_way_q}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = do_access ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (rd_way_q == last_way) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      set_bits_q    <= lsac_pkg::SET_BITS_RST;
      ways_q        <= lsac_pkg::WAYS_RST;
      block_bits_q  <= lsac_pkg::BLOCK_BITS_RST;
      clr_q         <= '0;
      issued_q      <= 1'b0;
      clock_q       <= '0;
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= (state_q == ST_SCAN);

      if (cfg.valid) begin
        unique case (cfg.index)
          lsac_pkg::CFG_SET_BITS:   set_bits_q   <= cfg.data[lsac_pkg::SB_W-1:0];
          lsac_pkg::CFG_WAYS:       ways_q       <= cfg.data[lsac_pkg::WAYS_W-1:0];
          lsac_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg.data[lsac_pkg::BB_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end

      if (finish_go) begin
        rsp_valid_q <= 1'b1;
        rsp_hits_q  <= acc_hits;
        rsp_miss_q  <= acc_miss;
        rsp_evict_q <= acc_evict;
        if (do_access) begin
          clock_q <= clock_next;
        end
        hit_total_q <= hit_sum[lsac_pkg::TOTAL_W] ? '1 : hit_sum[lsac_pkg::TOTAL_W-1:0];
        if (acc_miss && miss_total_q != '1) begin
          miss_total_q <= miss_total_q + 1'b1;
        end
        if (acc_evict && evict_total_q != '1) begin
          evict_total_q <= evict_total_q + 1'b1;
        end
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req.valid) begin
      mode_q <= req.mode;
      addr_q <= req.address;
    end
    if (state_q == ST_PREP) begin
      set_q    <= addr_sh[lsac_pkg::SET_W-1:0] & set_mask;
      tag_q    <= addr_q >> tag_shift;
      rd_way_q <= '0;
      hit_q    <= 1'b0;
      full_q   <= 1'b1;
    end
    if (state_q == ST_SCAN) begin
      cmp_way_q <= rd_way_q;
      if (rd_way_q != last_way) begin
        rd_way_q <= rd_way_q + 1'b1;
      end
    end
    if (issued_q) begin
      if (!hit_q && cmp_res.match) begin
        hit_q     <= 1'b1;
        hit_way_q <= cmp_way_q;
      end
      if (!ram_rdata.valid) begin
        full_q      <= 1'b0;
        empty_way_q <= cmp_way_q;
      end
      if (cmp_way_q == '0 || cmp_res.older) begin
        oldest_q <= ram_rdata.stamp;
        victim_q <= cmp_way_q;
      end
    end
  end

  assign req.ready           = (state_q == ST_IDLE);
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = rsp_valid_q;
  assign rsp.hit_count       = rsp_hits_q;
  assign rsp.missed          = rsp_miss_q;
  assign rsp.evicted         = rsp_evict_q;
  assign rsp.total_hits      = hit_total_q;
  assign rsp.total_misses    = miss_total_q;
  assign rsp.total_evictions = evict_total_q;

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req.ready)
    else $error("Request taken during the clearing pass.");

  a_evict_implies_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_evict_q) |-> (rsp_miss_q && rsp_hits_q != 2'd2))
    else $error("Eviction reported without a single miss.");

  a_compare_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("Line compare outside the scan.");

  a_totals_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (hit_total_q >= $past(hit_total_q)
                              && miss_total_q >= $past(miss_total_q)))
    else $error("Running total decreased.");

endmodule

FILE: test/lsac_result_check.sv
`timescale 1ns / 100ps
// Result checker for the LRU set-associative cache tag model. It predicts each result from the
// accepted requests and register writes, then compares every returned item field by field.
// Depends on lsac_pkg and the request, result and configuration channel interfaces.
module lsac_result_check (
  input  logic clk_i,
  input  logic rst_ni,
  lsac_req_if  req,
  lsac_rsp_if  rsp,
  lsac_cfg_if  cfg,
  output int   fail_cnt_o,
  output int   pending_o
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [lsac_pkg::HITS_W-1:0]  hit_count;
    logic                         missed;
    logic                         evicted;
    logic [lsac_pkg::TOTAL_W-1:0] total_hits;
    logic [lsac_pkg::TOTAL_W-1:0] total_misses;
    logic [lsac_pkg::TOTAL_W-1:0] total_evictions;
  } access_result_t;

  logic                         way_valid [lsac_pkg::NUM_LINES];
  logic [lsac_pkg::TAG_W-1:0]   way_tag   [lsac_pkg::NUM_LINES];
  logic [lsac_pkg::STAMP_W-1:0] way_stamp [lsac_pkg::NUM_LINES];
  logic [lsac_pkg::STAMP_W-1:0] use_clock;
  logic [lsac_pkg::TOTAL_W-1:0] hit_sum;
  logic [lsac_pkg::TOTAL_W-1:0] miss_sum;
  logic [lsac_pkg::TOTAL_W-1:0] evict_sum;
  logic [lsac_pkg::SB_W-1:0]    set_bits;
  logic [lsac_pkg::WAYS_W-1:0]  ways_in_use;
  logic [lsac_pkg::BB_W-1:0]    block_bits;
  access_result_t               awaited_q [$];
  int                           fail_cnt;

  function automatic logic [lsac_pkg::TOTAL_W-1:0] bump_total(
      input logic [lsac_pkg::TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic lookup_fill(input logic [lsac_pkg::ADDR_W-1:0] addr,
                                       inout logic missed, inout logic evicted);
    int                           sb;
    int                           ways;
    int                           set_idx;
    int                           base;
    int                           victim;
    int                           empty;
    int                           w;
    logic                         full;
    logic [lsac_pkg::TAG_W-1:0]   tag;
    logic [lsac_pkg::STAMP_W-1:0] oldest;
    logic [lsac_pkg::LINE_AW-1:0] li;
    sb = (set_bits > lsac_pkg::MAX_SET_BITS) ? lsac_pkg::MAX_SET_BITS : int'(set_bits);
    ways = (ways_in_use == 0) ? 1 : int'(ways_in_use);
    if (ways > lsac_pkg::MAX_WAYS) ways = lsac_pkg::MAX_WAYS;
    set_idx = int'((addr >> block_bits) & ((64'd1 << sb) - 64'd1));
    tag = addr >> (sb + int'(block_bits));
    base = set_idx * lsac_pkg::MAX_WAYS;
    full = 1'b1;
    empty = 0;
    for (w = 0; w < ways; w++) begin
      li = lsac_pkg::LINE_AW'(base + w);
      if (way_valid[li] && way_tag[li] == tag) begin
        use_clock = use_clock + 1'b1;
        way_stamp[li] = use_clock;
        hit_sum = bump_total(hit_sum);
        return 1'b1;
      end
      if (!way_valid[li]) begin
        full = 1'b0;
        empty = w;
      end
    end
    missed = 1'b1;
    miss_sum = bump_total(miss_sum);
    if (full) begin
      victim = 0;
      oldest = way_stamp[lsac_pkg::LINE_AW'(base)];
      for (w = 1; w < ways; w++) begin
        li = lsac_pkg::LINE_AW'(base + w);
        if (way_stamp[li] < oldest) begin
          oldest = way_stamp[li];
          victim = w;
        end
      end
      evicted = 1'b1;
      evict_sum = bump_total(evict_sum);
    end else begin
      victim = empty;
    end
    use_clock = use_clock + 1'b1;
    li = lsac_pkg::LINE_AW'(base + victim);
    way_valid[li] = 1'b1;
    way_tag[li] = tag;
    way_stamp[li] = use_clock;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t              want;
    access_result_t              got;
    logic                        missed;
    logic                        evicted;
    logic [lsac_pkg::HITS_W-1:0] hits;
    if (!rst_ni) begin
      for (int i = 0; i < lsac_pkg::NUM_LINES; i++) begin
        way_valid[lsac_pkg::LINE_AW'(i)] = 1'b0;
        way_tag[lsac_pkg::LINE_AW'(i)] = '0;
        way_stamp[lsac_pkg::LINE_AW'(i)] = '0;
      end
      use_clock = '0;
      hit_sum = '0;
      miss_sum = '0;
      evict_sum = '0;
      set_bits = lsac_pkg::SET_BITS_RST;
      ways_in_use = lsac_pkg::WAYS_RST;
      block_bits = lsac_pkg::BLOCK_BITS_RST;
      awaited_q.delete();
      fail_cnt = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit_count, rsp.missed, rsp.evicted,
                rsp.total_hits, rsp.total_misses, rsp.total_evictions};
        if (awaited_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("%0t: result item with none outstanding: hits=%0d miss=%0d evict=%0d",
                     $realtime, got.hit_count, got.missed, got.evicted);
          end
        end else begin
          want = awaited_q.pop_front();
          if (got.hit_count !== want.hit_count || got.missed !== want.missed ||
              got.evicted !== want.evicted || got.total_hits !== want.total_hits ||
              got.total_misses !== want.total_misses ||
              got.total_evictions !== want.total_evictions) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX) begin
              $display("%0t: mismatch expected hits=%0d miss=%0d evict=%0d totals=%0d/%0d/%0d",
                       $realtime, want.hit_count, want.missed, want.evicted,
                       want.total_hits, want.total_misses, want.total_evictions);
              $display("%0t:          actual   hits=%0d miss=%0d evict=%0d totals=%0d/%0d/%0d",
                       $realtime, got.hit_count, got.missed, got.evicted,
                       got.total_hits, got.total_misses, got.total_evictions);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lsac_pkg::CFG_SET_BITS: begin
            set_bits = cfg.data[lsac_pkg::SB_W-1:0];
          end
          lsac_pkg::CFG_WAYS: begin
            ways_in_use = cfg.data[lsac_pkg::WAYS_W-1:0];
          end
          lsac_pkg::CFG_BLOCK_BITS: begin
            block_bits = cfg.data[lsac_pkg::BB_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (req.valid && req.ready) begin
        missed = 1'b0;
        evicted = 1'b0;
        hits = '0;
        if (req.mode != lsac_pkg::MODE_NONE) begin
          hits = hits + lsac_pkg::HITS_W'(lookup_fill(req.address, missed, evicted));
        end
        if (req.mode == lsac_pkg::MODE_MODIFY) begin
          hits = hits + lsac_pkg::HITS_W'(lookup_fill(req.address, missed, evicted));
        end
        want = '{hits, missed, evicted, hit_sum, miss_sum, evict_sum};
        awaited_q.push_back(want);
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o <= awaited_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the LRU set-associative cache tag model: clock, reset, access and
// register-write stimulus, random result stalls, a watchdog and the final verdict.
// Depends on lsac_pkg, the channel interfaces, the block and lsac_result_check.
module tb_top;

  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 24;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 40;
  localparam int POOL_MAX    = 10;
  localparam int POOL_IDX_W  = $clog2(POOL_MAX);

  localparam logic [lsac_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                        clk_i;
  logic                        rst_ni;
  int                          fail_cnt;
  int                          pending;
  int                          idle_cycles;
  logic [lsac_pkg::TAG_W-1:0]  tag_pool [POOL_MAX];
  int                          pool_used;
  logic [lsac_pkg::SB_W-1:0]   cur_sb;
  logic [lsac_pkg::WAYS_W-1:0] cur_ways;
  logic [lsac_pkg::BB_W-1:0]   cur_bb;

  lsac_req_if req ();
  lsac_rsp_if rsp ();
  lsac_cfg_if cfg ();

  lru_set_assoc_cache_sim_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg)
  );

  lsac_result_check i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [lsac_pkg::MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return lsac_pkg::MODE_LOAD;
    if (r < 65) return lsac_pkg::MODE_STORE;
    if (r < 90) return lsac_pkg::MODE_MODIFY;
    return lsac_pkg::MODE_NONE;
  endfunction

  // Most addresses reuse a few tags and sets so that hits and LRU evictions happen.
  function automatic logic [lsac_pkg::ADDR_W-1:0] pick_address();
    int                          sbe;
    int                          nsets;
    int                          set_idx;
    logic [lsac_pkg::TAG_W-1:0]  tag;
    logic [lsac_pkg::ADDR_W-1:0] offset;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    sbe = (cur_sb > lsac_pkg::MAX_SET_BITS) ? lsac_pkg::MAX_SET_BITS : int'(cur_sb);
    nsets = 1 << sbe;
    if ($urandom_range(0, 9) < 7) set_idx = $urandom_range(0, ((nsets > 4) ? 4 : nsets) - 1);
    else set_idx = $urandom_range(0, nsets - 1);
    tag = tag_pool[POOL_IDX_W'($urandom_range(0, pool_used - 1))];
    offset = {$urandom, $urandom} & ((64'd1 << cur_bb) - 64'd1);
    return (tag << (sbe + int'(cur_bb))) | (lsac_pkg::ADDR_W'(set_idx) << cur_bb) | offset;
  endfunction

  task automatic send_access(input logic [lsac_pkg::MODE_W-1:0] mode,
                             input logic [lsac_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.address <= addr;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic write_reg(input logic [lsac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lsac_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if ($urandom_range(0, 1) == 1) begin
        rsp.ready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk_i);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int sb_tab   [8] = '{2, 0, 6, 7, 3, 1, 5, 0};
    int ways_tab [8] = '{4, 8, 8, 15, 0, 2, 3, 1};
    int bb_tab   [8] = '{4, 0, 16, 31, 5, 2, 7, 0};
    int eff_ways;
    req.valid = 1'b0;
    req.mode = lsac_pkg::MODE_LOAD;
    req.address = '0;
    cfg.valid = 1'b0;
    cfg.index = lsac_pkg::CFG_SET_BITS;
    cfg.data = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: 16 sets, one way, 16-byte blocks.
    send_access(lsac_pkg::MODE_LOAD,   64'h0);
    send_access(lsac_pkg::MODE_LOAD,   64'h0F);
    send_access(lsac_pkg::MODE_STORE,  64'h0);
    send_access(lsac_pkg::MODE_MODIFY, 64'h100);
    send_access(lsac_pkg::MODE_MODIFY, 64'h100);
    send_access(lsac_pkg::MODE_NONE,   64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lsac_pkg::MODE_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
    send_access(lsac_pkg::MODE_STORE,  64'hFFFF_FFFF_FFFF_FFF0);
    send_access(lsac_pkg::MODE_LOAD,   64'hFFFF_FFFF_FFFF_FF0F);
    send_access(lsac_pkg::MODE_STORE,  64'h8000_0000_0000_0000);
    send_access(lsac_pkg::MODE_MODIFY, 64'h0000_0000_0000_0010);
    send_access(lsac_pkg::MODE_MODIFY, 64'h5555_5555_5555_5555);
    send_access(lsac_pkg::MODE_NONE,   64'h0);
    send_access(lsac_pkg::MODE_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      if (phase < 8) begin
        cur_sb = lsac_pkg::SB_W'(sb_tab[phase]);
        cur_ways = lsac_pkg::WAYS_W'(ways_tab[phase]);
        cur_bb = lsac_pkg::BB_W'(bb_tab[phase]);
      end else begin
        cur_sb = lsac_pkg::SB_W'($urandom_range(0, 7));
        cur_ways = lsac_pkg::WAYS_W'($urandom_range(0, 15));
        cur_bb = lsac_pkg::BB_W'($urandom_range(0, 20));
      end
      // Upper data bits beyond each register's width are ignored by the block.
      write_reg(lsac_pkg::CFG_SET_BITS, {2'($urandom), cur_sb});
      write_reg(lsac_pkg::CFG_WAYS, {1'($urandom), cur_ways});
      write_reg(lsac_pkg::CFG_BLOCK_BITS, cur_bb);
      if (phase == 0) write_reg(CFG_UNUSED, lsac_pkg::CFG_DATA_W'($urandom));
      cfg.valid <= 1'b0;
      eff_ways = (cur_ways == 0) ? 1
               : ((cur_ways > lsac_pkg::MAX_WAYS) ? lsac_pkg::MAX_WAYS : int'(cur_ways));
      pool_used = eff_ways + 2;
      for (int i = 0; i < POOL_MAX; i++) tag_pool[POOL_IDX_W'(i)] = {$urandom, $urandom};
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_access(pick_mode(), pick_address());
    end
    drain();

    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
